// File: sv/qvic_pkg.sv
// Shared types and constants of the queued vectored interrupt controller.
package qvic_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ENTRY_W             = 6;
   localparam int DATA_W              = 32;
   localparam int LOCAL_W             = 5;
   localparam int LINE_W              = 6;

   localparam logic [DATA_W-1:0] MASK_MAIN_RST  = 32'hffff_ffff;
   localparam logic [DATA_W-1:0] MASK_EXT_RST   = 32'h0000_00ff;
   localparam logic [DATA_W-1:0] POLARITY_RST   = 32'h0000_03ff;
   localparam logic [DATA_W-1:0] EDGE_MODE_RST  = 32'h0000_03ff;
   localparam logic [DATA_W-1:0] IRQ_VECTOR_RST = 32'h00ff_ff00;
   localparam logic [DATA_W-1:0] FIQ_VECTOR_RST = 32'h00ff_fe00;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_RAISE = 2'd2,
      ACT_TICK  = 2'd3
   } qvic_action_type;

   typedef enum logic [3:0] {
      REG_ENB        = 4'd0,
      REG_ENB_EX     = 4'd1,
      REG_STA        = 4'd2,
      REG_STA_EX     = 4'd3,
      REG_MSK        = 4'd4,
      REG_MSK_EX     = 4'd5,
      REG_PR         = 4'd6,
      REG_PR_EX      = 4'd7,
      REG_POL        = 4'd8,
      REG_EDG        = 4'd9,
      REG_IRQVEC     = 4'd10,
      REG_FIQVEC     = 4'd11,
      REG_SETSTA     = 4'd12,
      REG_SETSTA_EX  = 4'd13,
      REG_CLRSTA     = 4'd14,
      REG_CLRSTA_EX  = 4'd15
   } qvic_reg_type;

endpackage

// File: sv/qvic_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qvic_ram
   import qvic_pkg::*;
#(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/queued_vectored_interrupt_controller_unit.sv
// Queued vectored interrupt controller: register file, pending queue and delivery.
//
// Usage:
//  - Request channel (req_*): one request per accepted valid/stall handshake. The
//    action selects a register read, a register write, a raised interrupt line
//    (lines 32..63 use the extended bank) or a delivery tick.
//  - Response channel (rsp_*): exactly one response per request, in request order.
//    Reads return data and status; writes return status; raised lines report
//    overflow when enabled and unmasked while the pending queue is full; ticks
//    pop the oldest pending entry and pulse irq or fiq with its bank-local number.
//  - Path: a request accepted into the input register moves to the registered
//    response stage when that stage is empty or its response is being taken.
//  - Throughput: one request per cycle unless rsp_stall holds a response. The queue is
//    a RAM read every cycle at the next head address; a push to it is forwarded.
//  - Stall: when rsp_stall holds a response, the input register holds too and
//    req_stall rises only while both stages are full.
//  - Reset: synchronous; control and architectural registers return to reset values,
//    the queue is empty and both channels are idle. No clearing pass is needed.
module queued_vectored_interrupt_controller_unit
   import qvic_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_reg_index,
   input  logic [DATA_W-1:0]  req_write_data,
   input  logic [LINE_W-1:0]  req_line,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_read_data,
   output logic               rsp_status,
   output logic               rsp_irq_pulse,
   output logic               rsp_fiq_pulse,
   output logic [LOCAL_W-1:0] rsp_vector_num,
   output logic               rsp_overflow
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;

   // input register
   logic                a_valid_ff, a_valid_in;
   qvic_action_type     a_action_ff;
   qvic_reg_type        a_index_ff;
   logic [DATA_W-1:0]   a_data_ff;
   logic [LINE_W-1:0]   a_line_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rd_data_ff, rd_data_in;
   logic                status_ff, status_in;
   logic                irq_ff, irq_in;
   logic                fiq_ff, fiq_in;
   logic [LOCAL_W-1:0]  num_ff, num_in;
   logic                ovf_ff, ovf_in;

   // architectural registers
   logic [DATA_W-1:0]   enable_main_ff, enable_main_in;
   logic [DATA_W-1:0]   enable_ext_ff, enable_ext_in;
   logic [DATA_W-1:0]   status_main_ff, status_main_in;
   logic [DATA_W-1:0]   status_ext_ff, status_ext_in;
   logic [DATA_W-1:0]   mask_main_ff, mask_main_in;
   logic [DATA_W-1:0]   mask_ext_ff, mask_ext_in;
   logic [DATA_W-1:0]   fast_main_ff, fast_main_in;
   logic [DATA_W-1:0]   fast_ext_ff, fast_ext_in;
   logic [DATA_W-1:0]   polarity_ff, polarity_in;
   logic [DATA_W-1:0]   edge_mode_ff, edge_mode_in;
   logic [DATA_W-1:0]   irq_vector_ff, irq_vector_in;
   logic [DATA_W-1:0]   fiq_vector_ff, fiq_vector_in;

   // queue control
   logic [CW-1:0]       queue_count_ff, queue_count_in;
   logic [AW-1:0]       queue_head_ff, queue_head_in;
   logic                byp_ff, byp_in;
   logic [ENTRY_W-1:0]  byp_data_ff;

   logic                advance;
   logic                accept;
   logic                fire;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic [SW-1:0]       tail_sum;
   logic [SW-1:0]       tail_wrap;
   logic [AW-1:0]       tail_addr;
   logic [ENTRY_W-1:0]  push_entry;
   logic [ENTRY_W-1:0]  ram_q;
   logic [ENTRY_W-1:0]  front_entry;
   logic [LOCAL_W-1:0]  line_local;
   logic                line_ext;
   logic [DATA_W-1:0]   line_bit;
   logic                line_hit;
   logic                line_fast;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = a_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign fire      = a_valid_ff && advance;

   assign line_local = a_line_ff[LOCAL_W-1:0];
   assign line_ext   = a_line_ff[LINE_W-1];
   assign line_bit   = DATA_W'(1) << line_local;
   assign line_hit   = line_ext
                       ? (enable_ext_ff[line_local] && !mask_ext_ff[line_local])
                       : (enable_main_ff[line_local] && !mask_main_ff[line_local]);
   assign line_fast  = line_ext ? fast_ext_ff[line_local] : fast_main_ff[line_local];

   assign queue_full = (queue_count_ff == CW'(QUEUE_DEPTH));
   assign push       = fire && (a_action_ff == ACT_RAISE) && line_hit && !queue_full;
   assign pop        = fire && (a_action_ff == ACT_TICK) && (queue_count_ff != '0);
   assign push_entry = {line_fast, line_local};

   assign tail_sum   = SW'(queue_head_ff) + SW'(queue_count_ff);
   assign tail_wrap  = (tail_sum >= SW'(QUEUE_DEPTH)) ? (tail_sum - SW'(QUEUE_DEPTH))
                                                        : tail_sum;
   assign tail_addr  = tail_wrap[AW-1:0];

   always_comb begin
      queue_head_in = queue_head_ff;
      if (pop) begin
         queue_head_in = (queue_head_ff == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                  : queue_head_ff + 1'b1;
      end
   end

   // RAM reads the next head each cycle; a push to that address is forwarded.
   assign byp_in      = push && (tail_addr == queue_head_in);
   assign front_entry = byp_ff ? byp_data_ff : ram_q;

   qvic_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_addr),
      .wr_data (push_entry),
      .rd_addr (queue_head_in),
      .rd_data (ram_q)
   );

   always_comb begin
      a_valid_in     = accept ? 1'b1 : (fire ? 1'b0 : a_valid_ff);
      rsp_valid_in   = fire ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

      enable_main_in = enable_main_ff;
      enable_ext_in  = enable_ext_ff;
      status_main_in = status_main_ff;
      status_ext_in  = status_ext_ff;
      mask_main_in   = mask_main_ff;
      mask_ext_in    = mask_ext_ff;
      fast_main_in   = fast_main_ff;
      fast_ext_in    = fast_ext_ff;
      polarity_in    = polarity_ff;
      edge_mode_in   = edge_mode_ff;
      irq_vector_in  = irq_vector_ff;
      fiq_vector_in  = fiq_vector_ff;
      queue_count_in = queue_count_ff;

      rd_data_in = '0;
      status_in  = 1'b0;
      irq_in     = 1'b0;
      fiq_in     = 1'b0;
      num_in     = '0;
      ovf_in     = 1'b0;

      unique case (a_action_ff)
         ACT_READ: begin
            unique case (a_index_ff)
               REG_ENB:       rd_data_in = enable_main_ff;
               REG_ENB_EX:    rd_data_in = enable_ext_ff;
               REG_STA:       rd_data_in = status_main_ff;
               REG_STA_EX:    rd_data_in = status_ext_ff;
               REG_MSK:       rd_data_in = mask_main_ff;
               REG_MSK_EX:    rd_data_in = mask_ext_ff;
               REG_PR:        rd_data_in = fast_main_ff;
               REG_PR_EX:     rd_data_in = fast_ext_ff;
               REG_POL:       rd_data_in = polarity_ff;
               REG_EDG:       rd_data_in = edge_mode_ff;
               REG_IRQVEC:    rd_data_in = irq_vector_ff;
               REG_FIQVEC:    rd_data_in = fiq_vector_ff;
               REG_SETSTA, REG_SETSTA_EX,
               REG_CLRSTA, REG_CLRSTA_EX: status_in = 1'b1;
            endcase
         end
         ACT_WRITE: begin
            unique case (a_index_ff)
               REG_ENB:       enable_main_in = a_data_ff;
               REG_ENB_EX:    enable_ext_in  = a_data_ff;
               REG_STA, REG_STA_EX: status_in = 1'b1;
               REG_MSK:       mask_main_in   = a_data_ff;
               REG_MSK_EX:    mask_ext_in    = a_data_ff;
               REG_PR:        fast_main_in   = a_data_ff;
               REG_PR_EX:     fast_ext_in    = a_data_ff;
               REG_POL:       polarity_in    = a_data_ff;
               REG_EDG:       edge_mode_in   = a_data_ff;
               REG_IRQVEC, REG_FIQVEC: ;
               REG_SETSTA:    status_main_in = status_main_ff | a_data_ff;
               REG_SETSTA_EX: status_ext_in  = status_ext_ff | a_data_ff;
               REG_CLRSTA:    status_main_in = status_main_ff & ~a_data_ff;
               REG_CLRSTA_EX: status_ext_in  = status_ext_ff & ~a_data_ff;
            endcase
         end
         ACT_RAISE: begin
            if (line_ext) begin
               status_ext_in = status_ext_ff | line_bit;
            end else begin
               status_main_in = status_main_ff | line_bit;
            end
            if (line_hit && queue_full) begin
               ovf_in = 1'b1;
            end
            if (push) begin
               queue_count_in = queue_count_ff + 1'b1;
            end
         end
         ACT_TICK: begin
            if (queue_count_ff != '0) begin
               queue_count_in = queue_count_ff - 1'b1;
               num_in         = front_entry[LOCAL_W-1:0];
               if (front_entry[ENTRY_W-1]) begin
                  fiq_vector_in = {{(DATA_W-LOCAL_W-2){1'b0}}, front_entry[LOCAL_W-1:0], 2'b00};
                  fiq_in        = 1'b1;
               end else begin
                  irq_vector_in = {{(DATA_W-LOCAL_W-2){1'b0}}, front_entry[LOCAL_W-1:0], 2'b00};
                  irq_in        = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byp_ff         <= 1'b0;
         queue_count_ff <= '0;
         queue_head_ff  <= '0;
         enable_main_ff <= '0;
         enable_ext_ff  <= '0;
         status_main_ff <= '0;
         status_ext_ff  <= '0;
         mask_main_ff   <= MASK_MAIN_RST;
         mask_ext_ff    <= MASK_EXT_RST;
         fast_main_ff   <= '0;
         fast_ext_ff    <= '0;
         polarity_ff    <= POLARITY_RST;
         edge_mode_ff   <= EDGE_MODE_RST;
         irq_vector_ff  <= IRQ_VECTOR_RST;
         fiq_vector_ff  <= FIQ_VECTOR_RST;
      end else begin
         a_valid_ff     <= a_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         byp_ff         <= byp_in;
         queue_head_ff  <= queue_head_in;
         if (fire) begin
            queue_count_ff <= queue_count_in;
            enable_main_ff <= enable_main_in;
            enable_ext_ff  <= enable_ext_in;
            status_main_ff <= status_main_in;
            status_ext_ff  <= status_ext_in;
            mask_main_ff   <= mask_main_in;
            mask_ext_ff    <= mask_ext_in;
            fast_main_ff   <= fast_main_in;
            fast_ext_ff    <= fast_ext_in;
            polarity_ff    <= polarity_in;
            edge_mode_ff   <= edge_mode_in;
            irq_vector_ff  <= irq_vector_in;
            fiq_vector_ff  <= fiq_vector_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= push_entry;
      if (accept) begin
         a_action_ff <= qvic_action_type'(req_action);
         a_index_ff  <= qvic_reg_type'(req_reg_index);
         a_data_ff   <= req_write_data;
         a_line_ff   <= req_line;
      end
      if (fire) begin
         rd_data_ff <= rd_data_in;
         status_ff  <= status_in;
         irq_ff     <= irq_in;
         fiq_ff     <= fiq_in;
         num_ff     <= num_in;
         ovf_ff     <= ovf_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rd_data_ff;
   assign rsp_status     = status_ff;
   assign rsp_irq_pulse  = irq_ff;
   assign rsp_fiq_pulse  = fiq_ff;
   assign rsp_vector_num = num_ff;
   assign rsp_overflow   = ovf_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count_ff <= CW'(QUEUE_DEPTH))
      else $error("pending count above queue depth");

   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(irq_ff && fiq_ff))
      else $error("irq and fiq delivered together");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push |=> queue_count_ff == $past(queue_count_ff) + 1'b1)
      else $error("push did not raise pending count");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (fire && ovf_in) |-> (queue_count_ff == CW'(QUEUE_DEPTH)) && !push)
      else $error("overflow while queue not full");
`endif

endmodule
